@@ rtl/gdd_pkg.sv @@
// ----------------------------------------------------------------------------
// gdd_pkg: Gregorian day difference shared definitions
// Field widths, status codes, microcode format, program ROM and calendar
// tables for the day difference sequencer.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  localparam int STAT_W  = 2;
  localparam int ORD_W   = 23;
  localparam int STEP_W  = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_START_BAD = 2'd1;
  localparam logic [STAT_W-1:0] STAT_END_BAD   = 2'd2;

  localparam logic SEL_START = 1'b0;
  localparam logic SEL_END   = 1'b1;

  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd10;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } seq_state_t;

  typedef enum logic [2:0] {
    UOP_LEAP,
    UOP_CHECK,
    UOP_YEARS,
    UOP_CENT,
    UOP_MONTH,
    UOP_EMIT
  } uop_t;

  typedef struct packed {
    uop_t              uop;
    logic              sel;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] pc);
    ctrl_word_t cw;
    case (pc)
      4'd0:    cw = '{UOP_LEAP,  SEL_START, STEP_EMIT};
      4'd1:    cw = '{UOP_LEAP,  SEL_END,   STEP_EMIT};
      4'd2:    cw = '{UOP_CHECK, SEL_START, STEP_EMIT};
      4'd3:    cw = '{UOP_CHECK, SEL_END,   STEP_EMIT};
      4'd4:    cw = '{UOP_YEARS, SEL_START, STEP_EMIT};
      4'd5:    cw = '{UOP_CENT,  SEL_START, STEP_EMIT};
      4'd6:    cw = '{UOP_MONTH, SEL_START, STEP_EMIT};
      4'd7:    cw = '{UOP_YEARS, SEL_END,   STEP_EMIT};
      4'd8:    cw = '{UOP_CENT,  SEL_END,   STEP_EMIT};
      4'd9:    cw = '{UOP_MONTH, SEL_END,   STEP_EMIT};
      default: cw = '{UOP_EMIT,  SEL_START, STEP_EMIT};
    endcase
    return cw;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
    logic [8:0] db;
    case (m)
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

endpackage

@@ rtl/gregorian_day_difference.sv @@
// ----------------------------------------------------------------------------
// gregorian_day_difference: days between two Gregorian dates
// Microcoded sequencer that validates two dates, converts each to an
// ordinal day number and emits the clamped, saturated difference.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. The block takes a new item only
// while idle; the microprogram then runs two leap-year steps, two validity
// checks, three ordinal steps per date and an emit step, one step per clock
// but for the emit step, which waits while the output register still holds
// an untaken result. A check that finds an invalid start or end date jumps
// straight to the emit step. Status 1 flags a bad start date, 2 a bad end
// date (start checked first); the count is then 0. A year above MAX_YEAR
// counts as invalid.
module gregorian_day_difference #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gdd_pkg::YEAR_W-1:0]   in_start_year,
  input  logic [gdd_pkg::MON_W-1:0]    in_start_month,
  input  logic [gdd_pkg::DAY_W-1:0]    in_start_day,
  input  logic [gdd_pkg::YEAR_W-1:0]   in_end_year,
  input  logic [gdd_pkg::MON_W-1:0]    in_end_month,
  input  logic [gdd_pkg::DAY_W-1:0]    in_end_day,
  input  logic                         in_count_end_day,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gdd_pkg::COUNT_W-1:0]  out_day_count,
  output logic [gdd_pkg::STAT_W-1:0]   out_date_status
);
  import gdd_pkg::*;

  localparam logic [YEAR_W:0] MAX_YEAR_V = (YEAR_W+1)'(MAX_YEAR);

  seq_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]   pc_r, pc_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [YEAR_W-1:0]   yr_r   [2];
  logic [MON_W-1:0]    mon_r  [2];
  logic [DAY_W-1:0]    day_r  [2];
  logic                inc_r;
  logic                leap_r [2];
  logic [ORD_W-1:0]    acc_r  [2];
  logic [STAT_W-1:0]   stat_r, stat_nxt;
  logic [COUNT_W-1:0]  cnt_out_r, cnt_out_nxt;
  logic [STAT_W-1:0]   stat_out_r, stat_out_nxt;

  ctrl_word_t          cw;
  logic                in_xfer;
  logic                out_free;
  logic [YEAR_W-1:0]   ysel;
  logic [MON_W-1:0]    msel;
  logic [DAY_W-1:0]    dsel;
  logic [ORD_W-1:0]    asel;
  logic [YEAR_W-1:0]   p;
  logic [26:0]         prod25;
  logic [9:0]          q25;
  logic [YEAR_W:0]     back25;
  logic                leap_calc;
  logic                date_ok;
  logic [22:0]         prod100;
  logic [7:0]          cent;
  logic [ORD_W-1:0]    acc_calc;
  logic [ORD_W-1:0]    diff;
  logic [ORD_W:0]      sum;

  assign in_stall  = (state_r == S_RUN);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_day_count   = cnt_out_r;
  assign out_date_status = stat_out_r;

  assign cw   = ucode(pc_r);
  assign ysel = yr_r[cw.sel];
  assign msel = mon_r[cw.sel];
  assign dsel = day_r[cw.sel];
  assign asel = acc_r[cw.sel];
  assign p    = ysel - 14'd1;

  // year divisible by 25 test via reciprocal multiply
  assign prod25    = ysel * 13'd5243;
  assign q25       = prod25[26:17];
  assign back25    = {1'b0, q25, 4'b0} + {2'b0, q25, 3'b0} + {5'b0, q25};
  assign leap_calc = (ysel[1:0] == 2'b00) &&
                     ((back25 != {1'b0, ysel}) || (ysel[3:0] == 4'b0000));

  assign date_ok = (ysel != '0) && ({1'b0, ysel} <= MAX_YEAR_V) &&
                   (msel >= 4'd1) && (msel <= 4'd12) && (dsel != '0) &&
                   (dsel <= month_days(msel, leap_r[cw.sel]));

  // p/100 = (p/4)/25
  assign prod100 = p[YEAR_W-1:2] * 11'd1311;
  assign cent    = prod100[22:15];

  always_comb begin
    case (cw.uop)
      UOP_YEARS: acc_calc = ORD_W'(p) * 23'd365 + 23'(p[YEAR_W-1:2]);
      UOP_CENT:  acc_calc = asel - 23'(cent) + 23'(cent[7:2]);
      UOP_MONTH: acc_calc = asel + 23'(days_before(msel)) +
                            23'((msel > 4'd2) && leap_r[cw.sel]) + 23'(dsel);
      default:   acc_calc = asel;
    endcase
  end

  assign diff = (acc_r[0] < acc_r[1]) ? (acc_r[1] - acc_r[0]) : '0;
  assign sum  = {1'b0, diff} + 24'(inc_r);

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r;
    stat_nxt      = stat_r;
    cnt_out_nxt   = cnt_out_r;
    stat_out_nxt  = stat_out_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_RUN;
          pc_nxt    = '0;
          stat_nxt  = STAT_OK;
        end
      end
      S_RUN: begin
        case (cw.uop)
          UOP_CHECK: begin
            if (!date_ok) begin
              stat_nxt = (cw.sel == SEL_END) ? STAT_END_BAD : STAT_START_BAD;
              pc_nxt   = cw.target;
            end else begin
              pc_nxt = pc_r + 4'd1;
            end
          end
          UOP_EMIT: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              stat_out_nxt  = stat_r;
              if (stat_r != STAT_OK) begin
                cnt_out_nxt = '0;
              end else if (sum > {2'b0, COUNT_MAX}) begin
                cnt_out_nxt = COUNT_MAX;
              end else begin
                cnt_out_nxt = sum[COUNT_W-1:0];
              end
              state_nxt = S_IDLE;
            end
          end
          default: pc_nxt = pc_r + 4'd1;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r     <= stat_nxt;
    cnt_out_r  <= cnt_out_nxt;
    stat_out_r <= stat_out_nxt;
    if (in_xfer) begin
      yr_r[SEL_START]  <= in_start_year;
      mon_r[SEL_START] <= in_start_month;
      day_r[SEL_START] <= in_start_day;
      yr_r[SEL_END]    <= in_end_year;
      mon_r[SEL_END]   <= in_end_month;
      day_r[SEL_END]   <= in_end_day;
      inc_r            <= in_count_end_day;
    end
    if (state_r == S_RUN) begin
      if (cw.uop == UOP_LEAP) begin
        leap_r[cw.sel] <= leap_calc;
      end
      if ((cw.uop == UOP_YEARS) || (cw.uop == UOP_CENT) || (cw.uop == UOP_MONTH)) begin
        acc_r[cw.sel] <= acc_calc;
      end
    end
  end

endmodule

@@ tb/tb_gregorian_day_difference.sv @@
// ----------------------------------------------------------------------------
// tb_gregorian_day_difference: self-checking bench for the day difference block
// Feeds directed and random date pairs through the input channel, predicts
// each count and status from the calendar rules and compares every result
// transfer in order, with random gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
module tb_gregorian_day_difference;
  import gdd_pkg::*;

  localparam int YEAR_LIMIT   = 9999;
  localparam int RANDOM_PAIRS = 75;
  localparam int QUIET_TAIL   = 20;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 100000;

  typedef struct {
    logic [YEAR_W-1:0] sy;
    logic [MON_W-1:0]  sm;
    logic [DAY_W-1:0]  sd;
    logic [YEAR_W-1:0] ey;
    logic [MON_W-1:0]  em;
    logic [DAY_W-1:0]  ed;
    logic              count_end;
  } date_pair_t;

  typedef struct {
    logic [COUNT_W-1:0] days;
    logic [STAT_W-1:0]  status;
  } span_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [YEAR_W-1:0]  in_start_year;
  logic [MON_W-1:0]   in_start_month;
  logic [DAY_W-1:0]   in_start_day;
  logic [YEAR_W-1:0]  in_end_year;
  logic [MON_W-1:0]   in_end_month;
  logic [DAY_W-1:0]   in_end_day;
  logic               in_count_end_day;
  logic               out_valid;
  logic               out_stall;
  logic [COUNT_W-1:0] out_day_count;
  logic [STAT_W-1:0]  out_date_status;

  date_pair_t pairs_to_send[$];
  span_t      spans_due[$];
  date_pair_t seen_pair;
  date_pair_t next_pair;
  span_t      due_span;

  logic in_taken;
  bit   calm;
  bit   finished;
  int   gap_left;
  int   hold_left;
  int   idle_cycles;
  int   mismatches;
  int   n_counted;
  int   n_start_bad;
  int   n_end_bad;

  gregorian_day_difference #(
    .MAX_YEAR(YEAR_LIMIT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_end_year      (in_end_year),
    .in_end_month     (in_end_month),
    .in_end_day       (in_end_day),
    .in_count_end_day (in_count_end_day),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_day_count    (out_day_count),
    .out_date_status  (out_date_status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    case (m)
      2:          return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
    if (y < 1 || y > YEAR_LIMIT) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return d >= 1 && d <= days_in_month(y, m);
  endfunction

  // Day 1 is January 1 of year 1.
  function automatic int unsigned day_number(int unsigned y, int unsigned m,
                                             int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) n += days_in_month(y, k);
    return n + d;
  endfunction

  function automatic span_t predict_span(date_pair_t p);
    span_t       r;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    r.days = '0;
    if (!date_ok(p.sy, p.sm, p.sd)) begin
      r.status = STAT_START_BAD;
    end else if (!date_ok(p.ey, p.em, p.ed)) begin
      r.status = STAT_END_BAD;
    end else begin
      a = day_number(p.sy, p.sm, p.sd);
      b = day_number(p.ey, p.em, p.ed);
      c = (a < b) ? b - a : 0;
      c += p.count_end;
      if (c > COUNT_MAX) c = COUNT_MAX;
      r.days   = c[COUNT_W-1:0];
      r.status = STAT_OK;
    end
    return r;
  endfunction

  task automatic add_pair(input int unsigned sy, sm, sd, ey, em, ed, c);
    date_pair_t p;
    p.sy        = sy[YEAR_W-1:0];
    p.sm        = sm[MON_W-1:0];
    p.sd        = sd[DAY_W-1:0];
    p.ey        = ey[YEAR_W-1:0];
    p.em        = em[MON_W-1:0];
    p.ed        = ed[DAY_W-1:0];
    p.count_end = c[0];
    pairs_to_send.push_back(p);
  endtask

  task automatic pick_date(output int unsigned y, m, d);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) y = $urandom_range(1, 3);
    else if (sel == 1) y = $urandom_range(YEAR_LIMIT - 2, YEAR_LIMIT);
    else if (sel < 4) y = $urandom_range(1595, 2405);
    else y = $urandom_range(1, YEAR_LIMIT);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, days_in_month(y, m));
    if ($urandom_range(0, 4) == 0) d = days_in_month(y, m);
  endtask

  task automatic add_random_pair();
    int unsigned kind;
    int unsigned sy, sm, sd, ey, em, ed, c;
    kind = $urandom_range(0, 19);
    c    = $urandom_range(0, 1);
    pick_date(sy, sm, sd);
    pick_date(ey, em, ed);
    if (kind >= 13 && kind <= 14) begin
      ey = sy;
      em = $urandom_range(1, 12);
      ed = $urandom_range(1, days_in_month(ey, em));
    end else if (kind == 15) begin
      ey = sy; em = sm; ed = sd;
    end else if (kind == 16) begin
      if ($urandom_range(0, 1)) ed = days_in_month(ey, em) + 1;
      else em = $urandom_range(13, 15);
    end else if (kind == 17) begin
      if ($urandom_range(0, 1)) sd = days_in_month(sy, sm) + 1;
      else sy = $urandom_range(YEAR_LIMIT + 1, (1 << YEAR_W) - 1);
    end else if (kind >= 18) begin
      sy = $urandom_range(0, (1 << YEAR_W) - 1);
      sm = $urandom_range(0, (1 << MON_W) - 1);
      sd = $urandom_range(0, (1 << DAY_W) - 1);
      ey = $urandom_range(0, (1 << YEAR_W) - 1);
      em = $urandom_range(0, (1 << MON_W) - 1);
      ed = $urandom_range(0, (1 << DAY_W) - 1);
    end
    add_pair(sy, sm, sd, ey, em, ed, c);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (!calm && gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pairs_to_send.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          gap_left = $urandom_range(0, 5);
        end else if (pairs_to_send.size() != 0) begin
          next_pair = pairs_to_send.pop_front();
          in_valid         <= 1'b1;
          in_start_year    <= next_pair.sy;
          in_start_month   <= next_pair.sm;
          in_start_day     <= next_pair.sd;
          in_end_year      <= next_pair.ey;
          in_end_month     <= next_pair.em;
          in_end_day       <= next_pair.ed;
          in_count_end_day <= next_pair.count_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (!calm && hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        hold_left = $urandom_range(0, 5);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (spans_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: count %0d status %0d",
                     out_day_count, out_date_status);
        end else begin
          due_span = spans_due.pop_front();
          if (out_day_count !== due_span.days || out_date_status !== due_span.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: count exp %0d got %0d, status exp %0d got %0d",
                       due_span.days, out_day_count, due_span.status, out_date_status);
          end
          if (due_span.status == STAT_OK) n_counted++;
          else if (due_span.status == STAT_START_BAD) n_start_bad++;
          else n_end_bad++;
        end
      end
      if (in_valid && !in_stall) begin
        seen_pair = '{in_start_year, in_start_month, in_start_day,
                      in_end_year, in_end_month, in_end_day, in_count_end_day};
        spans_due.push_back(predict_span(seen_pair));
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if (rst_n && !finished) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_start_year    = '0;
    in_start_month   = '0;
    in_start_day     = '0;
    in_end_year      = '0;
    in_end_month     = '0;
    in_end_day       = '0;
    in_count_end_day = 1'b0;
    out_stall        = 1'b0;
    in_taken         = 1'b0;
    calm             = 1'b0;
    finished         = 1'b0;
    gap_left         = 0;
    hold_left        = 0;
    idle_cycles      = 0;
    mismatches       = 0;
    n_counted        = 0;
    n_start_bad      = 0;
    n_end_bad        = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    add_pair(1, 1, 1, 9999, 12, 31, 1);      // widest span
    add_pair(1, 1, 1, 9999, 12, 31, 0);
    add_pair(2024, 5, 17, 2024, 5, 17, 1);   // same date
    add_pair(2024, 5, 17, 2024, 5, 17, 0);
    add_pair(9999, 12, 31, 1, 1, 1, 1);      // start after end
    add_pair(2000, 2, 29, 2100, 2, 28, 0);
    add_pair(1900, 2, 29, 2000, 1, 1, 1);    // century, not leap
    add_pair(2023, 1, 1, 2023, 2, 29, 0);
    add_pair(2024, 2, 28, 2024, 3, 1, 0);
    add_pair(2023, 2, 28, 2023, 3, 1, 1);
    add_pair(1999, 12, 31, 2000, 1, 1, 0);
    add_pair(0, 6, 15, 2000, 1, 1, 0);
    add_pair(2000, 1, 1, 10000, 1, 1, 1);
    add_pair(16383, 15, 31, 16383, 15, 31, 1);
    add_pair(2000, 0, 10, 2001, 1, 1, 0);
    add_pair(2000, 13, 1, 2001, 1, 1, 1);
    add_pair(2000, 1, 1, 2000, 4, 31, 1);
    add_pair(2000, 1, 0, 2000, 1, 1, 0);
    add_pair(2000, 1, 31, 2000, 12, 31, 0);
    add_pair(2000, 1, 1, 2000, 0, 0, 1);
    add_pair(0, 0, 0, 0, 0, 0, 1);           // both bad, start wins
    add_pair(1, 1, 1, 1, 1, 2, 0);
    add_pair(9999, 12, 30, 9999, 12, 31, 1);
    add_pair(1600, 2, 29, 1700, 2, 29, 0);
    add_pair(8191, 8, 16, 4096, 4, 8, 1);

    // let the directed set drain completely before the random part
    while (pairs_to_send.size() != 0 || in_valid || spans_due.size() != 0)
      @(posedge clk);

    for (int i = 0; i < RANDOM_PAIRS; i++) add_random_pair();

    while (pairs_to_send.size() > QUIET_TAIL) @(posedge clk);
    calm = 1'b1;
    while (pairs_to_send.size() != 0 || in_valid) @(posedge clk);
    while (spans_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    finished = 1'b1;

    if (spans_due.size() != 0) mismatches += spans_due.size();
    $display("Covered %0d date pairs: %0d counted, %0d bad start, %0d bad end.",
             n_counted + n_start_bad + n_end_bad, n_counted, n_start_bad, n_end_bad);
    $display("Input gaps and output stalls were random, with a full drain mid-run.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gdd_pkg.sv
rtl/gregorian_day_difference.sv
tb/tb_gregorian_day_difference.sv
